// ===== rtl/periodic_timer_bank_scan_top_defines.svh =====
// Assertion macros used by the timer bank sequencer.
`ifndef PERIODIC_TIMER_BANK_SCAN_TOP_DEFINES_SVH
`define PERIODIC_TIMER_BANK_SCAN_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/ptbs_pkg.sv =====
// Package: constants, types and helpers of the periodic timer bank.
package ptbs_pkg;

    localparam int TIMER_COUNT = 32;
    localparam int IDX_W       = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
    localparam int COUNT_W     = 16;
    localparam int FIDX_W      = 5;

    localparam logic [COUNT_W-1:0] STOPPED_MARK = 16'hFFFF;
    localparam logic [COUNT_W-1:0] PRESET_BASE  = 16'hF000;

    typedef enum logic [2:0] {
        ACT_TICK   = 3'd0,
        ACT_INIT   = 3'd1,
        ACT_STOP   = 3'd2,
        ACT_SCAN   = 3'd3,
        ACT_PRESET = 3'd4
    } action_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_DRAIN,
        ST_FILL,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic               we;
        logic [IDX_W-1:0]   waddr;
        logic [COUNT_W-1:0] wdata;
        logic               re;
        logic [IDX_W-1:0]   raddr;
    } ram_req_t;

    typedef struct packed {
        logic              done;
        logic              fired;
        logic [FIDX_W-1:0] fired_index;
        logic              init_rejected;
    } result_t;

    // low five bits of a timer index, zero-extended for small banks
    function automatic logic [FIDX_W-1:0] fired_idx(logic [IDX_W-1:0] i);
        logic [IDX_W+FIDX_W-1:0] w;
        w = {{FIDX_W{1'b0}}, i};
        return w[FIDX_W-1:0];
    endfunction

endpackage

// ===== rtl/periodic_timer_bank_scan_top.sv =====
// Periodic timer bank: an item is taken when start is high and busy is low.
// Tick and scan sweep the count/period memories, one entry a cycle; a scan
// ends early on a hit. Preset, init and stop also end in the done strobe.
// One item at a time; done is a one-cycle strobe the receiver cannot stall.
// Reset (rst_n low, asynchronous) clears all counts and periods at once.
module periodic_timer_bank_scan_top (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [2:0]                   action,
    input  logic [4:0]                   timer_index,
    input  logic [ptbs_pkg::COUNT_W-1:0] period,
    input  logic [ptbs_pkg::COUNT_W-1:0] start_count,
    output logic                         done,
    output logic                         fired,
    output logic [4:0]                   fired_index,
    output logic                         init_rejected
);

    import ptbs_pkg::*;

    ram_req_t           count_req;
    ram_req_t           period_req;
    logic [COUNT_W-1:0] count_rdata;
    logic [COUNT_W-1:0] period_rdata;
    result_t            res;

    logic               done_reg;
    logic               fired_reg;
    logic [FIDX_W-1:0]  fired_index_reg;
    logic               rej_reg;

    ptbs_seq u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .action       (action),
        .timer_index  (timer_index),
        .period       (period),
        .start_count  (start_count),
        .count_rdata  (count_rdata),
        .period_rdata (period_rdata),
        .count_req    (count_req),
        .period_req   (period_req),
        .res          (res)
    );

    ptbs_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (TIMER_COUNT),
        .AW    (IDX_W)
    ) u_count_ram (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (count_req.we),
        .waddr (count_req.waddr),
        .wdata (count_req.wdata),
        .re    (count_req.re),
        .raddr (count_req.raddr),
        .rdata (count_rdata)
    );

    ptbs_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (TIMER_COUNT),
        .AW    (IDX_W)
    ) u_period_ram (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (period_req.we),
        .waddr (period_req.waddr),
        .wdata (period_req.wdata),
        .re    (period_req.re),
        .raddr (period_req.raddr),
        .rdata (period_rdata)
    );

    // output register for the result word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= res.done;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.done)
        begin
            fired_reg       <= res.fired;
            fired_index_reg <= res.fired_index;
            rej_reg         <= res.init_rejected;
        end
    end

    assign done          = done_reg;
    assign fired         = fired_reg;
    assign fired_index   = fired_index_reg;
    assign init_rejected = rej_reg;

endmodule

// ===== rtl/ptbs_ram.sv =====
// Generic single-write, single-read RAM with per-entry valid bits cleared at reset.
module ptbs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (we)
        begin
            valid_reg[waddr] <= 1'b1;
        end
    end

    // an entry never written reads as its reset value of zero
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= valid_reg[raddr] ? mem[raddr] : '0;
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/ptbs_seq.sv =====
// Sequencer: sweeps the count and period memories for tick and scan, fills the counts for preset.
`include "periodic_timer_bank_scan_top_defines.svh"

module ptbs_seq (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [2:0]                      action,
    input  logic [4:0]                      timer_index,
    input  logic [ptbs_pkg::COUNT_W-1:0]    period,
    input  logic [ptbs_pkg::COUNT_W-1:0]    start_count,
    input  logic [ptbs_pkg::COUNT_W-1:0]    count_rdata,
    input  logic [ptbs_pkg::COUNT_W-1:0]    period_rdata,
    output ptbs_pkg::ram_req_t              count_req,
    output ptbs_pkg::ram_req_t              period_req,
    output ptbs_pkg::result_t               res
);

    import ptbs_pkg::*;

    state_t             state_reg, state_next;
    logic [2:0]         act_reg, act_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic               in_range_reg, in_range_next;
    logic [COUNT_W-1:0] per_reg, per_next;
    logic [COUNT_W-1:0] start_reg, start_next;
    logic [IDX_W-1:0]   rd_idx_reg, rd_idx_next;
    logic               p_vld_reg, p_vld_next;
    logic [IDX_W-1:0]   p_idx_reg, p_idx_next;
    logic               fired_reg, fired_next;
    logic [FIDX_W-1:0]  fidx_reg, fidx_next;
    logic               rej_reg, rej_next;

    logic                      accept;
    logic                      rd_last;
    logic                      hit;
    logic [IDX_W+FIDX_W-1:0]   idx_ext;

    assign busy    = (state_reg != ST_IDLE);
    assign accept  = start && !busy;
    assign rd_last = (rd_idx_reg == IDX_W'(TIMER_COUNT - 1));
    assign idx_ext = {{IDX_W{1'b0}}, timer_index};

    // scan condition on the entry whose read data has just come back
    assign hit = p_vld_reg && (act_reg == ACT_SCAN) && (period_rdata != '0) &&
                 (count_rdata != STOPPED_MARK) && (count_rdata >= period_rdata);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (action)
                        ACT_TICK, ACT_SCAN: state_next = ST_SWEEP;
                        ACT_PRESET:         state_next = ST_FILL;
                        default:            state_next = ST_DONE;
                    endcase
                end
            end
            ST_SWEEP:
            begin
                if (hit)
                begin
                    state_next = ST_DONE;
                end
                else if (rd_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: state_next = ST_DONE;
            ST_FILL:
            begin
                if (rd_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:  state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // datapath registers and memory requests
    always_comb
    begin
        act_next      = act_reg;
        idx_next      = idx_reg;
        in_range_next = in_range_reg;
        per_next      = per_reg;
        start_next    = start_reg;
        rd_idx_next   = rd_idx_reg;
        p_vld_next    = 1'b0;
        p_idx_next    = p_idx_reg;
        fired_next    = fired_reg;
        fidx_next     = fidx_reg;
        rej_next      = rej_reg;

        count_req  = '0;
        period_req = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    act_next      = action;
                    idx_next      = idx_ext[IDX_W-1:0];
                    in_range_next = (idx_ext < (IDX_W+FIDX_W)'(TIMER_COUNT));
                    per_next      = period;
                    start_next    = start_count;
                    rd_idx_next   = '0;
                    fired_next    = 1'b0;
                    fidx_next     = '0;
                    rej_next      = (action == ACT_INIT) && (period == '0);
                end
            end
            ST_SWEEP, ST_DRAIN:
            begin
                if (state_reg == ST_SWEEP)
                begin
                    count_req.re    = 1'b1;
                    count_req.raddr = rd_idx_reg;
                    period_req.re   = 1'b1;
                    period_req.raddr = rd_idx_reg;
                    p_vld_next      = !hit;
                    p_idx_next      = rd_idx_reg;
                    rd_idx_next     = rd_idx_reg + IDX_W'(1);
                end
                count_req.waddr = p_idx_reg;
                if (act_reg == ACT_SCAN)
                begin
                    count_req.we    = hit;
                    count_req.wdata = '0;
                    if (hit)
                    begin
                        fired_next = 1'b1;
                        fidx_next  = fired_idx(p_idx_reg);
                    end
                end
                else
                begin
                    count_req.we    = p_vld_reg;
                    count_req.wdata = (count_rdata == STOPPED_MARK) ? count_rdata
                                      : count_rdata + COUNT_W'(1);
                end
            end
            ST_FILL:
            begin
                count_req.we    = 1'b1;
                count_req.waddr = rd_idx_reg;
                count_req.wdata = PRESET_BASE + COUNT_W'({rd_idx_reg, 1'b0});
                rd_idx_next     = rd_idx_reg + IDX_W'(1);
            end
            ST_DONE:
            begin
                count_req.waddr  = idx_reg;
                period_req.waddr = idx_reg;
                period_req.wdata = per_reg;
                if ((act_reg == ACT_INIT) && in_range_reg && (per_reg != '0))
                begin
                    count_req.we    = 1'b1;
                    count_req.wdata = start_reg;
                    period_req.we   = 1'b1;
                end
                else if ((act_reg == ACT_STOP) && in_range_reg)
                begin
                    count_req.we    = 1'b1;
                    count_req.wdata = STOPPED_MARK;
                end
            end
            default:
            begin
                p_vld_next = 1'b0;
            end
        endcase
    end

    // result word for the output register
    always_comb
    begin
        res.done          = (state_reg == ST_DONE);
        res.fired         = fired_reg;
        res.fired_index   = fidx_reg;
        res.init_rejected = rej_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            p_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            p_vld_reg <= p_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg      <= act_next;
        idx_reg      <= idx_next;
        in_range_reg <= in_range_next;
        per_reg      <= per_next;
        start_reg    <= start_next;
        rd_idx_reg   <= rd_idx_next;
        p_idx_reg    <= p_idx_next;
        fired_reg    <= fired_next;
        fidx_reg     <= fidx_next;
        rej_reg      <= rej_next;
    end

    `ASSERT_NXT(a_accept_busy, clk, rst_n, accept, busy)
    `ASSERT_IMP(a_idle_no_write, clk, rst_n, state_reg == ST_IDLE, !count_req.we && !period_req.we)
    `ASSERT_IMP(a_pipe_in_sweep, clk, rst_n, p_vld_reg, state_reg == ST_SWEEP || state_reg == ST_DRAIN)
    `ASSERT_IMP(a_fired_scan, clk, rst_n, res.done && res.fired, act_reg == ACT_SCAN)
    `ASSERT_IMP(a_reject_init, clk, rst_n, res.done && res.init_rejected, act_reg == ACT_INIT && per_reg == '0)

endmodule
